[hdl/b64e_pkg.sv]
// ---------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table for the Base64 encoder.
// ---------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned LEN_BITS_DEF = 16;
  localparam logic [15:0] CAP_RESET    = 16'd256;
  localparam logic [7:0]  PAD_CHAR     = 8'h3D;  // '='
  localparam logic [7:0]  ERR_CHAR     = 8'h00;

  // position of the next byte within its 3-byte group
  typedef enum logic [1:0] {
    PH_ZERO = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  // one byte's worth of output characters, queued between front and back
  typedef struct packed {
    logic [3:0][7:0] chars;     // chars[0] goes out first
    logic [1:0]      last_idx;  // index of the last valid character
    logic            fin;       // last character ends the message
    logic            ovf;       // last character carries overflow
    logic            err;       // group overrun result
  } job_t;

  // map a 6-bit code onto the RFC 4648 alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] code);
    logic [7:0] c;
    begin
      c = {2'b00, code};
      if (code < 6'd26) begin
        b64_char = 8'h41 + c;
      end else if (code < 6'd52) begin
        b64_char = 8'h61 + c - 8'd26;
      end else if (code < 6'd62) begin
        b64_char = 8'h30 + c - 8'd52;
      end else if (code == 6'd62) begin
        b64_char = 8'h2B;
      end else begin
        b64_char = 8'h2F;
      end
    end
  endfunction

endpackage

[hdl/b64e_if.sv]
// ---------------------------------------------------------------------------
// b64e_in_if / b64e_out_if
// Valid/ready stream channels for raw bytes in and Base64 characters out.
// ---------------------------------------------------------------------------
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_msg;

  modport source (output valid, output data_byte, output end_of_msg, input ready);
  modport sink   (input valid, input data_byte, input end_of_msg, output ready);
endinterface

interface b64e_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        final_res;
  logic        overflow;
  logic [15:0] encoded_len;

  modport source (output valid, output out_char, output final_res, output overflow,
                  output encoded_len, input ready);
  modport sink   (input valid, input out_char, input final_res, input overflow,
                  input encoded_len, output ready);
endinterface

[hdl/b64e_front.sv]
// ---------------------------------------------------------------------------
// b64e_front
// Accept bytes, track group phase and carry, build character requests.
// ---------------------------------------------------------------------------
module b64e_front #(
  parameter int unsigned LEN_BITS = b64e_pkg::LEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  input  logic [15:0]          capacity,
  output logic                 push,
  output b64e_pkg::job_t       job,
  output logic [LEN_BITS-1:0]  len_base
);
  import b64e_pkg::*;

  localparam int unsigned CW = ((LEN_BITS > 16) ? LEN_BITS : 16) + 1;

  phase_t              phase_r, phase_nxt;
  logic [3:0]          carry_r, carry_nxt;
  logic [LEN_BITS-1:0] count_r, count_nxt;
  logic                aborted_r, aborted_nxt;

  logic [2:0]          n_add;
  logic [LEN_BITS-1:0] cnt_sum;
  logic [CW-1:0]       cnt_ext, cap_ext, sum_ext;
  logic                grp_err, term_ovf;

  assign cnt_ext  = CW'(count_r);
  assign cap_ext  = CW'(capacity);
  assign grp_err  = (phase_r != PH_ONE) && (phase_r != PH_TWO) &&
                    ((cnt_ext + CW'(4)) > cap_ext);

  always_comb begin
    case (phase_r)
      PH_ONE:  n_add = last ? 3'd3 : 3'd1;
      PH_TWO:  n_add = 3'd2;
      default: n_add = last ? 3'd4 : 3'd1;
    endcase
  end

  assign cnt_sum  = count_r + LEN_BITS'(n_add);
  assign sum_ext  = CW'(cnt_sum);
  assign term_ovf = sum_ext >= cap_ext;
  assign len_base = count_r;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    carry_nxt   = carry_r;
    count_nxt   = count_r;
    aborted_nxt = aborted_r;
    if (acc) begin
      if (aborted_r || grp_err || last) begin
        if (last) begin
          phase_nxt   = PH_ZERO;
          carry_nxt   = 4'd0;
          count_nxt   = '0;
          aborted_nxt = 1'b0;
        end else if (!aborted_r) begin
          aborted_nxt = 1'b1;
        end
      end else begin
        count_nxt = cnt_sum;
        case (phase_r)
          PH_ONE: begin
            phase_nxt = PH_TWO;
            carry_nxt = data_byte[3:0];
          end
          PH_TWO: begin
            phase_nxt = PH_ZERO;
            carry_nxt = 4'd0;
          end
          default: begin
            phase_nxt = PH_ONE;
            carry_nxt = {2'b00, data_byte[1:0]};
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    job  = '0;
    push = acc && !aborted_r;
    case (phase_r)
      PH_ONE: begin
        job.chars[0] = b64_char({carry_r[1:0], data_byte[7:4]});
        job.chars[1] = b64_char({data_byte[3:0], 2'b00});
        job.chars[2] = PAD_CHAR;
        job.last_idx = last ? 2'd2 : 2'd0;
      end
      PH_TWO: begin
        job.chars[0] = b64_char({carry_r, data_byte[7:6]});
        job.chars[1] = b64_char(data_byte[5:0]);
        job.last_idx = 2'd1;
      end
      default: begin
        if (grp_err) begin
          job.chars[0] = ERR_CHAR;
          job.last_idx = 2'd0;
          job.err      = 1'b1;
        end else begin
          job.chars[0] = b64_char(data_byte[7:2]);
          job.chars[1] = b64_char({data_byte[1:0], 4'b0000});
          job.chars[2] = PAD_CHAR;
          job.chars[3] = PAD_CHAR;
          job.last_idx = last ? 2'd3 : 2'd0;
        end
      end
    endcase
    job.fin = grp_err || last;
    job.ovf = grp_err || (last && term_ovf);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ZERO;
      carry_r   <= 4'd0;
      count_r   <= '0;
      aborted_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      carry_r   <= carry_nxt;
      count_r   <= count_nxt;
      aborted_r <= aborted_nxt;
    end
  end

  a_abort_phase: assert property (@(posedge clk) disable iff (!rst_n)
    aborted_r |-> (phase_r == PH_ZERO && carry_r == 4'd0))
    else $error("aborted message left a partial group");

  a_abort_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && aborted_r) |-> !push)
    else $error("swallowed byte produced a request");

endmodule

[hdl/b64e_queue.sv]
// ---------------------------------------------------------------------------
// b64e_queue
// Two-entry request queue between the front and the character back end.
// ---------------------------------------------------------------------------
module b64e_queue #(
  parameter int unsigned LEN_BITS = b64e_pkg::LEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64e_pkg::job_t      push_job,
  input  logic [LEN_BITS-1:0] push_len,
  output logic                can_push,
  input  logic                pop,
  output logic                head_valid,
  output b64e_pkg::job_t      head_job,
  output logic [LEN_BITS-1:0] head_len
);
  import b64e_pkg::*;

  job_t                job_r [2];
  logic [LEN_BITS-1:0] len_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          count_r, count_nxt;

  assign can_push   = count_r != 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_job   = job_r[rd_ptr_r];
  assign head_len   = len_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job_r[wr_ptr_r] <= push_job;
      len_r[wr_ptr_r] <= push_len;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !can_push) && !(pop && !head_valid))
    else $error("queue pushed while full or popped while empty");

endmodule

[hdl/b64e_back.sv]
// ---------------------------------------------------------------------------
// b64e_back
// Serialize queued requests into one output character per cycle while out_ch is ready.
// ---------------------------------------------------------------------------
module b64e_back #(
  parameter int unsigned LEN_BITS = b64e_pkg::LEN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  b64e_pkg::job_t      head_job,
  input  logic [LEN_BITS-1:0] head_len,
  output logic                pop,
  b64e_out_if.source          out_ch
);
  import b64e_pkg::*;

  logic [1:0]          idx_r, idx_nxt;
  logic                valid_r, valid_nxt;
  logic [7:0]          char_r;
  logic                fin_r, ovf_r;
  logic [LEN_BITS-1:0] len_r;
  logic                load, at_last;

  assign load    = head_valid && (!valid_r || out_ch.ready);
  assign at_last = idx_r == head_job.last_idx;
  assign pop     = load && at_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) begin
      idx_nxt   = at_last ? 2'd0 : idx_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= head_job.chars[idx_r];
      fin_r  <= head_job.fin && at_last;
      ovf_r  <= head_job.ovf && at_last;
      len_r  <= head_job.err ? head_len
                             : head_len + LEN_BITS'(idx_r) + LEN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.out_char    = char_r;
  assign out_ch.final_res   = fin_r;
  assign out_ch.overflow    = ovf_r;
  assign out_ch.encoded_len = 16'(len_r);

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r <= head_job.last_idx))
    else $error("character index ran past the request");

  a_ovf_final: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && ovf_r) |-> fin_r)
    else $error("overflow flagged on a result that does not end the message");

endmodule

[hdl/base64_stream_encoder_top.sv]
// ---------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming Base64 encoder (RFC 4648 alphabet, '=' padding), byte in, char out.
// ---------------------------------------------------------------------------
// Feed one raw byte per request on in_ch, with end_of_msg set on the final
// byte of each message; characters come out one per request on out_ch. The
// front end takes a byte in any cycle in which its two-entry request queue
// has room, so bytes may follow each other back to back. The back end drives
// exactly one character per cycle from its output register while a request
// is queued and out_ch is ready. A byte makes one to four characters, so a
// long message is bounded by that single output register. Before the first
// character of every group, the count plus four is checked against cfg
// capacity; on an overrun a single zero character with final_res and overflow
// goes out and the remaining bytes of the message are dropped silently.
// The last character of a message also carries overflow when no room is
// left for a terminator. Write cfg_wdata with cfg_we only while the block
// is idle; capacity resets to 256.
// ---------------------------------------------------------------------------
module base64_stream_encoder_top #(
  parameter int unsigned LEN_BITS = b64e_pkg::LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  b64e_in_if.sink     in_ch,
  b64e_out_if.source  out_ch
);
  import b64e_pkg::*;

  logic [15:0]         capacity_r;

  // front to queue
  logic                fr_push;
  job_t                fr_job;
  logic [LEN_BITS-1:0] fr_len;
  logic                q_can_push;

  // queue to back
  logic                q_valid;
  job_t                q_job;
  logic [LEN_BITS-1:0] q_len;
  logic                bk_pop;

  logic                in_acc;

  // hold capacity until the next write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  // accept whenever the queue can take a request; swallowed bytes need no room
  // but are held to the same rule to keep the ready path short
  assign in_ch.ready = q_can_push;
  assign in_acc      = in_ch.valid && q_can_push;

  b64e_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .data_byte (in_ch.data_byte),
    .last      (in_ch.end_of_msg),
    .capacity  (capacity_r),
    .push      (fr_push),
    .job       (fr_job),
    .len_base  (fr_len)
  );

  b64e_queue #(.LEN_BITS(LEN_BITS)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fr_push),
    .push_job   (fr_job),
    .push_len   (fr_len),
    .can_push   (q_can_push),
    .pop        (bk_pop),
    .head_valid (q_valid),
    .head_job   (q_job),
    .head_len   (q_len)
  );

  b64e_back #(.LEN_BITS(LEN_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (q_job),
    .head_len   (q_len),
    .pop        (bk_pop),
    .out_ch     (out_ch)
  );

endmodule
